@@ hw/rtl/dckv_pkg.sv @@
package dckv_pkg;

    // Event kinds carried on the result channel
    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VELOCITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_VELOCITY = 2'd3;
    localparam int unsigned CFG_DATA_W = 7;

    // Reset values of the configuration registers
    localparam logic [6:0] RST_BASE_NOTE    = 7'd60;
    localparam logic [3:0] RST_MIDI_CHANNEL = 4'd0;
    localparam logic [6:0] RST_MIN_VELOCITY = 7'd20;
    localparam logic [6:0] RST_TOP_VELOCITY = 7'd127;

    // Highest MIDI note number
    localparam logic [6:0] NOTE_MAX = 7'd127;

    // Per-key tracker result for one sample
    typedef struct packed {
        logic        emit;
        logic        kind;
        logic [31:0] elapsed;
    } t_key_evt;

endpackage

@@ hw/rtl/dckv_keys.sv @@
module dckv_keys
    import dckv_pkg::*;
#(
    parameter int KEY_COUNT = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_upd,
    input  logic [4:0]  i_key,
    input  logic        i_first,
    input  logic        i_second,
    input  logic [31:0] i_now,
    output t_key_evt    o_evt
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // Per-key contact flags, note flag and first-contact time
    logic [KEY_COUNT-1:0] r_first;
    logic [KEY_COUNT-1:0] r_second;
    logic [KEY_COUNT-1:0] r_note;
    logic [31:0]          r_time [KEY_COUNT];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             fa;
    logic             sa;
    logic             non;
    logic             first_new;
    logic             on_hit;
    logic             off_hit;
    logic             n_note;

    assign in_range = 32'(i_key) < 32'(KEY_COUNT);
    assign idx      = IDX_W'(i_key);
    assign fa       = in_range ? r_first[idx]  : 1'b0;
    assign sa       = in_range ? r_second[idx] : 1'b0;
    assign non      = in_range ? r_note[idx]   : 1'b0;

    // Fresh first contact restarts the press timer
    assign first_new = i_first && !fa;

    // Fresh second contact with first held and silent key -> note-on;
    // both contacts open while sounding -> note-off
    assign on_hit  = in_range && i_second && !sa && i_first && !non;
    assign off_hit = in_range && !i_first && !i_second && non;
    assign n_note  = on_hit ? 1'b1 : (off_hit ? 1'b0 : non);

    always_comb begin
        o_evt.emit    = on_hit || off_hit;
        o_evt.kind    = on_hit ? EV_NOTE_ON : EV_NOTE_OFF;
        o_evt.elapsed = first_new ? 32'd0 : (i_now - r_time[idx]);
    end

    // Flag update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_note   <= '0;
        end else if (i_upd && in_range) begin
            r_first[idx]  <= i_first;
            r_second[idx] <= i_second;
            r_note[idx]   <= n_note;
        end
    end

    // Timestamp store, only read after its first-contact flag is set
    always_ff @(posedge i_clk) begin
        if (i_upd && in_range && first_new) begin
            r_time[idx] <= i_now;
        end
    end

endmodule

@@ hw/rtl/dual_contact_key_velocity_scan.sv @@
// Dual-contact key velocity scanner.
// Input channel: i_valid / o_stall with one key sample per word (key index,
// both contact bits, millisecond timestamp). A word is taken on a rising
// edge with i_valid high and o_stall low; one word per cycle is sustained
// while the receiver does not stall. Output channel: o_valid / i_stall, one
// note-on or note-off word per sample that causes one; samples that cause
// nothing, and keys at or above KEY_COUNT, leave no word.
// A sample passes the input, middle and output registers in turn. It sits
// in the input register while the per-key state is updated and the
// velocity span multiply runs; the middle register then feeds the
// divide-by-MAX_PRESS_MS reciprocal multiply into the output register.
// When the receiver stalls, the output word holds and the stages behind it
// keep filling; o_stall rises only when all three stages hold words.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
// for the user to write only while the block is idle; it does not enforce this.
// Synchronous active-low reset clears the per-key flags, empties the pipeline
// and loads base note 60, channel 0, velocity range 20..127.
module dual_contact_key_velocity_scan
    import dckv_pkg::*;
#(
    parameter int KEY_COUNT    = 24,
    parameter int MAX_PRESS_MS = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [4:0]            i_key_index,
    input  logic                  i_first_contact,
    input  logic                  i_second_contact,
    input  logic [31:0]           i_now_ms,
    // event output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_event_kind,
    output logic [4:0]            o_key_number,
    output logic [6:0]            o_note_number,
    output logic [6:0]            o_note_velocity,
    output logic [3:0]            o_channel
);

    // Widths of the velocity datapath
    localparam int D_W     = $clog2(MAX_PRESS_MS + 1);
    localparam int PROD_W  = D_W + 7;
    localparam int C_LOG   = $clog2(MAX_PRESS_MS);
    localparam int SHIFT   = PROD_W + C_LOG + 1;
    localparam int RECIP_W = SHIFT - C_LOG + 1;
    localparam logic [63:0] RECIP_64 =
        ((64'd1 << SHIFT) + 64'(MAX_PRESS_MS) - 64'd1) / 64'(MAX_PRESS_MS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];
    localparam int QPROD_W = PROD_W + RECIP_W;

    // Configuration registers
    logic [6:0] r_base_note;
    logic [3:0] r_channel;
    logic [6:0] r_min_vel;
    logic [6:0] r_max_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_note <= RST_BASE_NOTE;
            r_channel   <= RST_MIDI_CHANNEL;
            r_min_vel   <= RST_MIN_VELOCITY;
            r_max_vel   <= RST_TOP_VELOCITY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_NOTE:    r_base_note <= i_cfg_data[6:0];
                REG_MIDI_CHANNEL: r_channel   <= i_cfg_data[3:0];
                REG_MIN_VELOCITY: r_min_vel   <= i_cfg_data[6:0];
                REG_TOP_VELOCITY: r_max_vel   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Velocity range; min above max collapses onto max
    logic [6:0] vel_hi;
    logic [6:0] vel_lo;
    logic [6:0] vel_span;

    assign vel_hi   = r_max_vel;
    assign vel_lo   = (r_min_vel > r_max_vel) ? r_max_vel : r_min_vel;
    assign vel_span = vel_hi - vel_lo;

    // Stage handshake
    logic r_iv;
    logic r_mv;
    logic r_ov;
    logic adv_o;
    logic adv_m;
    logic adv_i;

    assign adv_o   = !r_ov || !i_stall;
    assign adv_m   = !r_mv || adv_o;
    assign adv_i   = !r_iv || adv_m;
    assign o_stall = !adv_i;

    // Input register
    logic [4:0]  r_i_key;
    logic        r_i_first;
    logic        r_i_second;
    logic [31:0] r_i_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (adv_i) begin
            r_iv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_i && i_valid) begin
            r_i_key    <= i_key_index;
            r_i_first  <= i_first_contact;
            r_i_second <= i_second_contact;
            r_i_now    <= i_now_ms;
        end
    end

    // Per-key state, committed as the sample leaves the input register
    t_key_evt key_evt;

    dckv_keys #(
        .KEY_COUNT (KEY_COUNT)
    ) u_keys (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (r_iv && adv_m),
        .i_key    (r_i_key),
        .i_first  (r_i_first),
        .i_second (r_i_second),
        .i_now    (r_i_now),
        .o_evt    (key_evt)
    );

    // Middle stage: elapsed classification and span product
    logic              d_zero;
    logic              d_over;
    logic [PROD_W-1:0] n_prod;
    logic              r_m_kind;
    logic [4:0]        r_m_key;
    logic              r_m_zero;
    logic              r_m_over;
    logic [PROD_W-1:0] r_m_prod;

    assign d_zero = key_evt.elapsed == 32'd0;
    assign d_over = key_evt.elapsed > 32'(MAX_PRESS_MS);
    assign n_prod = PROD_W'(key_evt.elapsed[D_W-1:0]) * PROD_W'(vel_span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (adv_m) begin
            r_mv <= r_iv && key_evt.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_m && r_iv) begin
            r_m_kind <= key_evt.kind;
            r_m_key  <= r_i_key;
            r_m_zero <= d_zero;
            r_m_over <= d_over;
            r_m_prod <= n_prod;
        end
    end

    // Output stage: divide by MAX_PRESS_MS through the reciprocal
    logic [QPROD_W-1:0] q_prod;
    logic [6:0]         drop_raw;
    logic [6:0]         drop;
    logic [6:0]         n_vel;
    logic [7:0]         note_sum;
    logic [6:0]         n_note;

    assign q_prod   = QPROD_W'(r_m_prod) * QPROD_W'(RECIP);
    assign drop_raw = q_prod[SHIFT+6:SHIFT];
    assign drop     = (drop_raw > vel_span) ? vel_span : drop_raw;

    always_comb begin
        if (r_m_kind == EV_NOTE_OFF) begin
            n_vel = 7'd0;
        end else if (r_m_zero) begin
            n_vel = vel_hi;
        end else if (r_m_over) begin
            n_vel = vel_lo;
        end else begin
            n_vel = vel_hi - drop;
        end
    end

    // Note number saturates at the top of the MIDI range
    assign note_sum = {1'b0, r_base_note} + {3'b000, r_m_key};
    assign n_note   = (note_sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : note_sum[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv_o) begin
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_mv) begin
            o_event_kind    <= r_m_kind;
            o_key_number    <= r_m_key;
            o_note_number   <= n_note;
            o_note_velocity <= n_vel;
            o_channel       <= r_channel;
        end
    end

    assign o_valid = r_ov;

    // Checks
    a_off_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == EV_NOTE_OFF |-> o_note_velocity == 7'd0)
        else $error("note-off word with nonzero velocity");

    a_on_vel_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == EV_NOTE_ON |-> o_note_velocity <= r_max_vel)
        else $error("note-on velocity above the velocity ceiling");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_iv && r_mv && r_ov && i_stall)
        else $error("input stalled with a free pipeline stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

@@ sim/tb_dual_contact_key_velocity_scan.sv @@
// One note event word as it leaves the scanner
typedef struct packed {
    logic       kind;
    logic [4:0] key;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] chan;
} t_note_event;

// Tracks per-key contact state and the note events the scanner owes
class note_event_tracker #(int KEYS = 24, int PRESS_MS = 100);
    logic [6:0]  base_note;
    logic [3:0]  chan;
    logic [6:0]  vel_min;
    logic [6:0]  vel_max;
    bit          first_on [KEYS];
    bit          second_on[KEYS];
    bit          sounding [KEYS];
    logic [31:0] first_ms [KEYS];
    t_note_event due_events[$];
    int          failures;

    function new();
        base_note = dckv_pkg::RST_BASE_NOTE;
        chan      = dckv_pkg::RST_MIDI_CHANNEL;
        vel_min   = dckv_pkg::RST_MIN_VELOCITY;
        vel_max   = dckv_pkg::RST_TOP_VELOCITY;
        for (int k = 0; k < KEYS; k++) begin
            first_on[k]  = 1'b0;
            second_on[k] = 1'b0;
            sounding[k]  = 1'b0;
            first_ms[k]  = '0;
        end
        failures = 0;
    endfunction

    function void set_reg(logic [dckv_pkg::CFG_IDX_W-1:0] idx, logic [6:0] data);
        case (idx)
            dckv_pkg::REG_BASE_NOTE:    base_note = data;
            dckv_pkg::REG_MIDI_CHANNEL: chan      = data[3:0];
            dckv_pkg::REG_MIN_VELOCITY: vel_min   = data;
            dckv_pkg::REG_TOP_VELOCITY: vel_max   = data;
            default: ;
        endcase
    endfunction

    // Linear falloff from max to min over the press window; min above max
    // collapses onto max
    function logic [6:0] velocity_for(logic [31:0] elapsed);
        int unsigned top;
        int unsigned bottom;
        int unsigned drop;
        top    = vel_max;
        bottom = (vel_min > vel_max) ? vel_max : vel_min;
        if (elapsed == 0) return vel_max;
        if (elapsed > PRESS_MS) return 7'(bottom);
        drop = (elapsed * (top - bottom)) / PRESS_MS;
        if (drop > top - bottom) drop = top - bottom;
        return 7'(top - drop);
    endfunction

    function void queue_event(logic kind, int key, logic [6:0] vel);
        t_note_event ev;
        int          sum;
        sum         = base_note + key;
        ev.kind     = kind;
        ev.key      = 5'(key);
        ev.note     = (sum > 127) ? dckv_pkg::NOTE_MAX : 7'(sum);
        ev.velocity = vel;
        ev.chan     = chan;
        due_events.push_back(ev);
    endfunction

    // Accepted sample: update the key and note any event it causes
    function void take_sample(logic [4:0] key, logic f, logic s, logic [31:0] now);
        int k;
        k = key;
        if (k >= KEYS) return;
        if (f && !first_on[k]) begin
            first_on[k] = 1'b1;
            first_ms[k] = now;
        end else if (!f && first_on[k]) begin
            first_on[k] = 1'b0;
        end
        if (s && !second_on[k]) begin
            second_on[k] = 1'b1;
            if (first_on[k] && !sounding[k]) begin
                sounding[k] = 1'b1;
                queue_event(dckv_pkg::EV_NOTE_ON, k, velocity_for(now - first_ms[k]));
                return;
            end
        end else if (!s && second_on[k]) begin
            second_on[k] = 1'b0;
        end
        if (!first_on[k] && !second_on[k] && sounding[k]) begin
            sounding[k] = 1'b0;
            queue_event(dckv_pkg::EV_NOTE_OFF, k, 7'd0);
        end
    endfunction

    // Accepted result word against the oldest owed event
    function void match_event(t_note_event got);
        t_note_event want;
        if (due_events.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected word kind=%0d key=%0d note=%0d vel=%0d ch=%0d",
                         $time, got.kind, got.key, got.note, got.velocity, got.chan);
            return;
        end
        want = due_events.pop_front();
        if (got !== want) begin
            failures++;
            if (failures <= 10) begin
                $write("%0t: mismatch exp kind=%0d key=%0d note=%0d vel=%0d ch=%0d",
                       $time, want.kind, want.key, want.note, want.velocity, want.chan);
                $display(", got kind=%0d key=%0d note=%0d vel=%0d ch=%0d",
                         got.kind, got.key, got.note, got.velocity, got.chan);
            end
        end
    endfunction

    function int owed();
        return due_events.size();
    endfunction
endclass

module tb_dual_contact_key_velocity_scan
    import dckv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic [4:0]            i_key_index      = '0;
    logic                  i_first_contact  = 1'b0;
    logic                  i_second_contact = 1'b0;
    logic [31:0]           i_now_ms         = '0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic                  o_event_kind;
    logic [4:0]            o_key_number;
    logic [6:0]            o_note_number;
    logic [6:0]            o_note_velocity;
    logic [3:0]            o_channel;

    note_event_tracker tracker;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_ticket   = 0;
    int          hold_seen     = 0;
    int          cycle_count   = 0;
    logic [31:0] clock_ms;
    int          key_stage[32];
    logic [4:0]  last_key      = '0;

    dual_contact_key_velocity_scan i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_key_index      (i_key_index),
        .i_first_contact  (i_first_contact),
        .i_second_contact (i_second_contact),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_key_number     (o_key_number),
        .o_note_number    (o_note_number),
        .o_note_velocity  (o_note_velocity),
        .o_channel        (o_channel)
    );

    always #1 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_ticket) begin
                hold_seen = hold_ticket;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.match_event({o_event_kind, o_key_number, o_note_number,
                                 o_note_velocity, o_channel});
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one sample word and wait until it is taken
    task automatic send_sample(input logic [4:0] key, input logic f, input logic s,
                               input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_key_index      <= key;
        i_first_contact  <= f;
        i_second_contact <= s;
        i_now_ms         <= now;
        do @(posedge i_clk); while (o_stall);
        tracker.take_sample(key, f, s, now);
    endtask

    // Stop sending, then wait for every owed event and the pipeline tail
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.owed() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Mostly well-formed presses (first, both, second up, all up) on a
    // running millisecond clock, with some noise and out-of-range keys
    task automatic play_random(input int n);
        int         counted;
        int         roll;
        logic [4:0] key;
        logic       f;
        logic       s;
        counted = 0;
        while (counted < n) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 55) key = last_key;
            else key = 5'($urandom_range(0, 23));
            if (roll < 3) clock_ms = $urandom;
            else clock_ms = clock_ms + 32'($urandom_range(0, 6));
            if (roll >= 82) begin
                key = 5'($urandom_range(0, 31));
                f   = 1'($urandom_range(0, 1));
                s   = 1'($urandom_range(0, 1));
            end else if ($urandom_range(0, 9) == 0) begin
                // held sample, nothing new
                f = (key_stage[key] != 0);
                s = (key_stage[key] == 2);
            end else begin
                case (key_stage[key])
                    0: begin
                        f = 1'b1; s = 1'b0; key_stage[key] = 1;
                    end
                    1: begin
                        if ($urandom_range(0, 4) != 0)
                            clock_ms = clock_ms + 32'($urandom_range(0, 120));
                        f = 1'b1; s = 1'b1; key_stage[key] = 2;
                    end
                    2: begin
                        f = 1'b1; s = 1'b0; key_stage[key] = 3;
                    end
                    default: begin
                        f = 1'b0; s = 1'b0; key_stage[key] = 0;
                    end
                endcase
            end
            send_sample(key, f, s, clock_ms);
            last_key = key;
            if (key < 24) counted++;
        end
    endtask

    initial begin
        tracker = new();
        for (int k = 0; k < 32; k++) key_stage[k] = 0;
        clock_ms = $urandom;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings
        send_idle_pct = 37;
        recv_idle_pct = 74;
        // zero elapsed at the top of the clock, then release
        send_sample(5'd0, 1'b1, 1'b0, 32'hFFFF_FFF0);
        send_sample(5'd0, 1'b1, 1'b1, 32'hFFFF_FFF0);
        send_sample(5'd0, 1'b0, 1'b1, 32'h0000_0000);
        send_sample(5'd0, 1'b0, 1'b0, 32'h0000_0001);
        // elapsed across the clock wrap, both contacts released at once
        send_sample(5'd23, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_sample(5'd23, 1'b1, 1'b1, 32'h0000_0031);
        send_sample(5'd23, 1'b0, 1'b0, 32'h0000_0040);
        // keys past the end are dropped
        send_sample(5'd24, 1'b1, 1'b1, 32'h0000_0050);
        send_sample(5'd31, 1'b1, 1'b1, 32'h8000_0000);
        // second contact alone, then first: no note
        send_sample(5'd5, 1'b0, 1'b1, 32'h0000_0100);
        send_sample(5'd5, 1'b1, 1'b1, 32'h0000_0110);
        send_sample(5'd5, 1'b0, 1'b0, 32'h0000_0120);
        // press at exactly the window edge
        send_sample(5'd7, 1'b1, 1'b0, 32'd1000);
        send_sample(5'd7, 1'b1, 1'b1, 32'd1100);
        send_sample(5'd7, 1'b0, 1'b0, 32'd1200);
        // press just past the window
        send_sample(5'd8, 1'b1, 1'b0, 32'd2000);
        send_sample(5'd8, 1'b1, 1'b1, 32'd2101);
        send_sample(5'd8, 1'b0, 1'b0, 32'd2200);
        // both contacts close in one sample
        send_sample(5'd16, 1'b1, 1'b1, 32'h5555_AAAA);
        send_sample(5'd16, 1'b0, 1'b0, 32'hAAAA_5555);
        settle();

        // Saturated notes, top channel, min above max
        write_reg(REG_BASE_NOTE, 7'd127);
        write_reg(REG_MIDI_CHANNEL, 7'd15);
        write_reg(REG_MIN_VELOCITY, 7'd127);
        write_reg(REG_TOP_VELOCITY, 7'd1);
        send_idle_pct = 37;
        recv_idle_pct = 74;
        play_random(170);
        settle();

        // Zero velocity registers, lowest base note
        write_reg(REG_BASE_NOTE, 7'd0);
        write_reg(REG_MIDI_CHANNEL, 7'd5);
        write_reg(REG_MIN_VELOCITY, 7'd0);
        write_reg(REG_TOP_VELOCITY, 7'd0);
        send_idle_pct = 74;
        recv_idle_pct = 37;
        play_random(170);
        settle();

        // Random ordinary setting, full speed, with a long receiver hold-off
        write_reg(REG_BASE_NOTE, 7'($urandom_range(100, 127)));
        write_reg(REG_MIDI_CHANNEL, 7'($urandom_range(0, 15)));
        write_reg(REG_MIN_VELOCITY, 7'($urandom_range(1, 40)));
        write_reg(REG_TOP_VELOCITY, 7'($urandom_range(90, 127)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ticket   = hold_ticket + 1;
        play_random(170);
        settle();

        if (tracker.failures == 0 && tracker.owed() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/dckv_pkg.sv
hw/rtl/dckv_keys.sv
hw/rtl/dual_contact_key_velocity_scan.sv
sim/tb_dual_contact_key_velocity_scan.sv
